// ----- src/e2q_pkg.sv -----
// e2q_pkg: shared types, constants and the arctangent table for the
// Euler angle to quaternion unit. Depends on nothing.
`timescale 1ns / 1ps
package e2q_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_COUNT   = 24;
	localparam int STEP_W       = 5;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} angle_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	// One CORDIC rotation: x, y in Q2.30, residual phase with 2^31 = pi
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} rot_t;

	// Index 0 roll, 1 pitch, 2 yaw
	typedef struct packed {
		logic          valid;
		rot_t [2:0]    r;
	} cell_t;

	localparam int ROLL  = 0;
	localparam int PITCH = 1;
	localparam int YAW   = 2;

	// atan(2^-i), 2^31 = pi
	function automatic logic signed [31:0] atan_lut(input logic [STEP_W-1:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0:  v = 32'sh20000000;
			5'd1:  v = 32'sh12E4051E;
			5'd2:  v = 32'sh09FB385B;
			5'd3:  v = 32'sh051111D4;
			5'd4:  v = 32'sh028B0D43;
			5'd5:  v = 32'sh0145D7E1;
			5'd6:  v = 32'sh00A2F61E;
			5'd7:  v = 32'sh00517C55;
			5'd8:  v = 32'sh0028BE53;
			5'd9:  v = 32'sh00145F2F;
			5'd10: v = 32'sh000A2F98;
			5'd11: v = 32'sh000517CC;
			5'd12: v = 32'sh00028BE6;
			5'd13: v = 32'sh000145F3;
			5'd14: v = 32'sh0000A2FA;
			5'd15: v = 32'sh0000517D;
			5'd16: v = 32'sh000028BE;
			5'd17: v = 32'sh0000145F;
			5'd18: v = 32'sh00000A30;
			5'd19: v = 32'sh00000518;
			5'd20: v = 32'sh0000028C;
			5'd21: v = 32'sh00000146;
			5'd22: v = 32'sh000000A3;
			default: v = 32'sh00000051;
		endcase
		return v;
	endfunction

endpackage

// ----- src/e2q_cordic_cell.sv -----
// e2q_cordic_cell: one registered CORDIC rotation step for all three angles.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_cordic_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [e2q_pkg::STEP_W-1:0]    step,
	input  e2q_pkg::cell_t                d,
	output e2q_pkg::cell_t                q
);

	e2q_pkg::cell_t       nxt;
	logic signed [31:0]   atan_v;
	logic                 valid_q;
	e2q_pkg::rot_t [2:0]  r_q;

	assign atan_v = e2q_pkg::atan_lut(step);

	// Rotate towards zero residual phase
	always_comb begin
		nxt.valid = d.valid;
		for (int a = 0; a < 3; a++) begin
			if (!d.r[a].z[31]) begin
				nxt.r[a].x = d.r[a].x - (d.r[a].y >>> step);
				nxt.r[a].y = d.r[a].y + (d.r[a].x >>> step);
				nxt.r[a].z = d.r[a].z - atan_v;
			end else begin
				nxt.r[a].x = d.r[a].x + (d.r[a].y >>> step);
				nxt.r[a].y = d.r[a].y - (d.r[a].x >>> step);
				nxt.r[a].z = d.r[a].z + atan_v;
			end
		end
	end

	// Advance valid under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.valid;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= nxt.r;
		end
	end

	assign q = {valid_q, r_q};

endmodule

// ----- src/e2q_combine.sv -----
// e2q_combine: pair products, triple products, rounding and saturation.
// Three registered stages, the last one drives the result beat. Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_combine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  e2q_pkg::cell_t  d,
	output logic            valid,
	output e2q_pkg::quat_t  quat
);

	function automatic logic signed [32:0] pair_rnd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] m;
		m = 64'(a) * 64'(b) + 64'sd536870912;
		return 33'(m >>> 30);
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [65:0] s);
		logic signed [65:0] r;
		r = (s + (66'sd1 <<< 44)) >>> 45;
		if (r > 66'sd32767)
			return 16'sh7FFF;
		else if (r < -66'sd32768)
			return 16'sh8000;
		return 16'(r);
	endfunction

	logic               valid_s1, valid_s2;
	logic signed [32:0] cycp_s1, sysp_s1, sycp_s1, cysp_s1;
	logic signed [31:0] cr_s1, sr_s1;
	logic signed [64:0] t_s2 [8];

	// Hold valids under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid    <= 1'b0;
		end else if (en) begin
			valid_s1 <= d.valid;
			valid_s2 <= valid_s1;
			valid    <= valid_s2;
		end
	end

	// Stage 1: yaw-pitch pair products
	always_ff @(posedge clk) begin
		if (en) begin
			cycp_s1 <= pair_rnd(d.r[e2q_pkg::YAW].x, d.r[e2q_pkg::PITCH].x);
			sysp_s1 <= pair_rnd(d.r[e2q_pkg::YAW].y, d.r[e2q_pkg::PITCH].y);
			sycp_s1 <= pair_rnd(d.r[e2q_pkg::YAW].y, d.r[e2q_pkg::PITCH].x);
			cysp_s1 <= pair_rnd(d.r[e2q_pkg::YAW].x, d.r[e2q_pkg::PITCH].y);
			cr_s1   <= d.r[e2q_pkg::ROLL].x;
			sr_s1   <= d.r[e2q_pkg::ROLL].y;
		end
	end

	// Stage 2: triple products with the roll terms
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2[0] <= 65'(cycp_s1) * 65'(cr_s1);
			t_s2[1] <= 65'(sysp_s1) * 65'(sr_s1);
			t_s2[2] <= 65'(cycp_s1) * 65'(sr_s1);
			t_s2[3] <= 65'(sysp_s1) * 65'(cr_s1);
			t_s2[4] <= 65'(sycp_s1) * 65'(cr_s1);
			t_s2[5] <= 65'(cysp_s1) * 65'(sr_s1);
			t_s2[6] <= 65'(cysp_s1) * 65'(cr_s1);
			t_s2[7] <= 65'(sycp_s1) * 65'(sr_s1);
		end
	end

	// Stage 3: sum, round to Q1.15 and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			quat.quat_w <= to_q15(66'(t_s2[0]) - 66'(t_s2[1]));
			quat.quat_x <= to_q15(66'(t_s2[2]) + 66'(t_s2[3]));
			quat.quat_y <= to_q15(66'(t_s2[4]) - 66'(t_s2[5]));
			quat.quat_z <= to_q15(66'(t_s2[6]) + 66'(t_s2[7]));
		end
	end

`ifndef ASSERT_OFF
	a_s1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		en && d.valid |=> valid_s1)
		else $error("valid beat lost entering stage 1");
	a_s2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 |=> valid_s2)
		else $error("valid beat lost entering stage 2");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s2) && $stable(t_s2[0]) && $stable(valid))
		else $error("pipeline moved while held");
`endif

endmodule

// ----- src/euler_to_quaternion_unit.sv -----
// Throughput: one beat per cycle; set by the chain of CORDIC cells and the
// three product stages, which all advance together whenever the result register is free.
// Reset: arst_n clears all valid flags at once; payload registers are not reset.
// Depends on e2q_pkg, e2q_cordic_cell and e2q_combine.
`timescale 1ns / 1ps
module euler_to_quaternion_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            angle_valid,
	output logic            angle_stall,
	input  e2q_pkg::angle_t angle,
	output logic            quat_valid,
	input  logic            quat_stall,
	output e2q_pkg::quat_t  quat
);

	logic           en;
	e2q_pkg::cell_t chain [e2q_pkg::CORDIC_STEPS + 1];

	// Advance the whole pipe while the result register is empty or being taken
	assign en          = !quat_valid || !quat_stall;
	assign angle_stall = !en;

	// Seed the first cell: gain constant, zero, half-angle phase (angle * 2^15)
	assign chain[0].valid             = angle_valid;
	assign chain[0].r[e2q_pkg::ROLL]  = '{e2q_pkg::GAIN_Q30, 32'sd0,
		{angle.roll_angle[15], angle.roll_angle, 15'h0}};
	assign chain[0].r[e2q_pkg::PITCH] = '{e2q_pkg::GAIN_Q30, 32'sd0,
		{angle.pitch_angle[15], angle.pitch_angle, 15'h0}};
	assign chain[0].r[e2q_pkg::YAW]   = '{e2q_pkg::GAIN_Q30, 32'sd0,
		{angle.yaw_angle[15], angle.yaw_angle, 15'h0}};

	for (genvar i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin : g_cell
		localparam int K = (i < e2q_pkg::ATAN_COUNT) ? i : e2q_pkg::ATAN_COUNT - 1;
		e2q_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (e2q_pkg::STEP_W'(K)),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	e2q_combine u_combine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (chain[e2q_pkg::CORDIC_STEPS]),
		.valid  (quat_valid),
		.quat   (quat)
	);

endmodule

// ----- tb/euler_to_quaternion_unit_tb.sv -----
// euler_to_quaternion_unit_tb: self-checking bench for the Euler angle to quaternion unit.
// Drives angle beats through a stimulus table and random triples, predicts each quaternion.
// Depends on e2q_pkg and euler_to_quaternion_unit.
`timescale 1ns / 1ps
module euler_to_quaternion_unit_tb;

	localparam int N_RANDOM = 400;
	localparam int N_TABLE  = 20;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            angle_valid = 1'b0;
	logic            angle_stall;
	e2q_pkg::angle_t angle = '0;
	logic            quat_valid;
	logic            quat_stall = 1'b0;
	e2q_pkg::quat_t  quat;

	e2q_pkg::quat_t  quat_pending[$];
	int     errors = 0;
	int     beats_in = 0;
	int     beats_out = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	bit     hold_off = 1'b0;
	bit     stim_done = 1'b0;

	// Directed rows: angles and, where obvious, the quaternion
	typedef struct {
		e2q_pkg::angle_t a;
		bit              known;
		e2q_pkg::quat_t  q;
	} row_t;
	row_t   stim_tab[N_TABLE];

	euler_to_quaternion_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.angle       (angle),
		.quat_valid  (quat_valid),
		.quat_stall  (quat_stall),
		.quat        (quat)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Half-angle cosine and sine by rotation-mode CORDIC, Q2.30
	function automatic void half_cs(input logic signed [15:0] ang,
			output longint c, output longint s);
		longint x, y, z, dx, dy;
		int     k;
		x = e2q_pkg::GAIN_Q30;
		y = 0;
		z = longint'(ang) * 32768;
		for (int i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin
			k = (i < e2q_pkg::ATAN_COUNT) ? i : e2q_pkg::ATAN_COUNT - 1;
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy;
				z -= longint'(e2q_pkg::atan_lut(k[e2q_pkg::STEP_W-1:0]));
			end else begin
				x += dx; y -= dy;
				z += longint'(e2q_pkg::atan_lut(k[e2q_pkg::STEP_W-1:0]));
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint trip(input longint a, input longint b, input longint c);
		longint p;
		p = (a * b + (longint'(1) << 29)) >>> 30;
		return p * c;
	endfunction

	function automatic logic signed [15:0] to_q15(input longint sum);
		longint r;
		r = (sum + (longint'(1) << 44)) >>> 45;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic e2q_pkg::quat_t quat_of(input e2q_pkg::angle_t a);
		longint cr, sr, cp, sp, cy, sy;
		e2q_pkg::quat_t q;
		half_cs(a.roll_angle, cr, sr);
		half_cs(a.pitch_angle, cp, sp);
		half_cs(a.yaw_angle, cy, sy);
		q.quat_w = to_q15(trip(cy, cp, cr) - trip(sy, sp, sr));
		q.quat_x = to_q15(trip(cy, cp, sr) + trip(sy, sp, cr));
		q.quat_y = to_q15(trip(sy, cp, cr) - trip(cy, sp, sr));
		q.quat_z = to_q15(trip(cy, sp, cr) + trip(sy, cp, sr));
		return q;
	endfunction

	function automatic row_t mk(input int r, input int p, input int y);
		row_t t;
		t.a = '{r[15:0], p[15:0], y[15:0]};
		t.known = 1'b0;
		t.q = '0;
		return t;
	endfunction

	// Fill the directed table: zero, extremes, single axes, all bits set
	initial begin
		stim_tab[0]  = mk(0, 0, 0);
		// w saturates at +1; the residual CORDIC phase leaves just over half an LSB of
		// negative sine, which rounds to -1 on the vector parts
		stim_tab[0].known = 1'b1;
		stim_tab[0].q = '{16'sd32767, -16'sd1, -16'sd1, -16'sd1};
		stim_tab[1]  = mk(-32768, 0, 0);
		stim_tab[2]  = mk(32767, 0, 0);
		stim_tab[3]  = mk(0, -32768, 0);
		stim_tab[4]  = mk(0, 32767, 0);
		stim_tab[5]  = mk(0, 0, -32768);
		stim_tab[6]  = mk(0, 0, 32767);
		stim_tab[7]  = mk(-32768, -32768, -32768);
		stim_tab[8]  = mk(32767, 32767, 32767);
		stim_tab[9]  = mk(-1, -1, -1);
		stim_tab[10] = mk(1, 1, 1);
		stim_tab[11] = mk(16384, 0, 0);
		stim_tab[12] = mk(0, 16384, 0);
		stim_tab[13] = mk(0, 0, 16384);
		stim_tab[14] = mk(-16384, 16384, -16384);
		stim_tab[15] = mk(21845, 0, 0);
		stim_tab[16] = mk(32767, -32768, 32767);
		stim_tab[17] = mk(16'h5555, 16'hAAAA, 16'h5555);
		stim_tab[18] = mk(16'hAAAA, 16'h5555, 16'hAAAA);
		stim_tab[19] = mk(8192, -8192, 24576);
	end

	// Offer one beat, idling first at random, and hold it until taken
	task automatic send_beat(input e2q_pkg::angle_t a);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			angle_valid <= 1'b0;
			@(posedge clk);
		end
		angle_valid <= 1'b1;
		angle <= a;
		quat_pending.push_back(quat_of(a));
		@(posedge clk);
		while (angle_stall)
			@(posedge clk);
		beats_in++;
	endtask

	// Sender: table, then random triples in three idling phases
	initial begin
		e2q_pkg::angle_t a;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 17;
		recv_idle_pct = 50;
		for (int i = 0; i < N_TABLE; i++) begin
			if (stim_tab[i].known && quat_of(stim_tab[i].a) != stim_tab[i].q) begin
				$error("table row %0d disagrees with predictor", i);
				errors++;
			end
			send_beat(stim_tab[i].a);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 17;
			end
			if (i == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (i == N_RANDOM / 2)
				hold_off = 1'b1;
			a.roll_angle = 16'($urandom);
			a.pitch_angle = 16'($urandom);
			a.yaw_angle = 16'($urandom);
			// bias some beats towards small roll angles
			if ($urandom_range(3) == 0)
				a.roll_angle = 16'($signed($urandom_range(64)) - 32);
			send_beat(a);
		end
		angle_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver stall: random, plus one long hold-off that fills the pipe
	always @(posedge clk) begin
		if (hold_off) begin
			quat_stall <= 1'b1;
			repeat (60) @(posedge clk);
			hold_off = 1'b0;
			quat_stall <= 1'b0;
		end else if (recv_idle_pct > 0) begin
			quat_stall <= ($urandom_range(99) < recv_idle_pct);
		end else begin
			quat_stall <= 1'b0;
		end
	end

	// Check each accepted quaternion against the oldest prediction
	always @(posedge clk) begin
		e2q_pkg::quat_t q;
		if (arst_n && quat_valid && !quat_stall) begin
			beats_out++;
			if (quat_pending.size() == 0) begin
				$error("unexpected quaternion beat %h", quat);
				errors++;
			end else begin
				q = quat_pending.pop_front();
				if (quat.quat_w !== q.quat_w) begin
					$error("quat_w expected %0d got %0d", q.quat_w, quat.quat_w); errors++;
				end
				if (quat.quat_x !== q.quat_x) begin
					$error("quat_x expected %0d got %0d", q.quat_x, quat.quat_x); errors++;
				end
				if (quat.quat_y !== q.quat_y) begin
					$error("quat_y expected %0d got %0d", q.quat_y, quat.quat_y); errors++;
				end
				if (quat.quat_z !== q.quat_z) begin
					$error("quat_z expected %0d got %0d", q.quat_z, quat.quat_z); errors++;
				end
			end
		end
	end

	// Drain, then report
	initial begin
		wait (stim_done);
		while (quat_pending.size() != 0)
			@(posedge clk);
		repeat (e2q_pkg::CORDIC_STEPS + 10) @(posedge clk);
		$display("Covered %0d angle beats and %0d quaternion beats, %0d directed rows.",
			beats_in, beats_out, N_TABLE);
		if (errors == 0 && quat_pending.size() == 0)
			$display("euler_to_quaternion_unit regression: pass");
		else
			$display("euler_to_quaternion_unit regression: fail");
		$finish;
	end

	// Timeout
	initial begin
		#2000000;
		$display("euler_to_quaternion_unit regression: fail");
		$finish;
	end

endmodule
